// File: sv/gaps_pkg.sv
// Shared types, constants and helpers for the grid A* path search block.
`default_nettype none
package gaps_pkg;

  localparam int GRID_SIDE  = 16;
  localparam int CELL_W     = 8;
  localparam int COORD_W    = 4;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int PATH_DEPTH = 256;
  localparam int LEN_W      = 9;
  localparam int COST_W     = 9;
  localparam int EST_W      = 5;
  localparam int F_W        = 10;
  localparam int LIMIT_W    = 16;

  localparam logic [COST_W-1:0]  COST_INF      = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd1000;
  localparam logic [LEN_W-1:0]   PATH_FULL_LEN = LEN_W'(PATH_DEPTH);

  localparam logic [1:0] ACT_MAP_WRITE = 2'd0;
  localparam logic [1:0] ACT_SEARCH    = 2'd1;
  localparam logic [1:0] ACT_PATH_READ = 2'd2;

  localparam logic [3:0] SIDE_UP    = 4'h1;
  localparam logic [3:0] SIDE_RIGHT = 4'h2;
  localparam logic [3:0] SIDE_DOWN  = 4'h4;
  localparam logic [3:0] SIDE_LEFT  = 4'h8;

  // per-cell search record
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [EST_W-1:0]  est;
    logic              no_parent;
    logic [CELL_W-1:0] parent;
    logic              closed;
  } node_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [LEN_W-1:0]  length;
  } eng_stat_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [CELL_W-1:0] loc;
  } path_wr_t;

  function automatic logic [EST_W-1:0] manhattan(input logic [CELL_W-1:0] a,
                                                 input logic [CELL_W-1:0] b);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (a[7:4] > b[7:4]) ? a[7:4] - b[7:4] : b[7:4] - a[7:4];
    dy = (a[3:0] > b[3:0]) ? a[3:0] - b[3:0] : b[3:0] - a[3:0];
    return EST_W'(dx) + EST_W'(dy);
  endfunction

endpackage
`default_nettype wire

// File: sv/gaps_path_store.sv
// Path store memory: written by the search engine, read by path read items.
`default_nettype none
module gaps_path_store (
  input  wire logic                     clk,
  input  wire gaps_pkg::path_wr_t       wr,
  input  wire logic [gaps_pkg::CELL_W-1:0] raddr,
  output logic      [gaps_pkg::CELL_W-1:0] rdata_r
);
  import gaps_pkg::*;

  logic [CELL_W-1:0] mem [PATH_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.loc;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/gaps_engine.sv
// A* search engine: map, node and open-list memories with the search sequencer.
`default_nettype none
module gaps_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          map_we,
  input  wire logic [gaps_pkg::CELL_W-1:0]   map_cell,
  input  wire logic [3:0]                    map_sides,
  input  wire logic                          search_go,
  input  wire logic [gaps_pkg::CELL_W-1:0]   start_cell,
  input  wire logic [gaps_pkg::CELL_W-1:0]   goal_cell,
  input  wire logic [gaps_pkg::LIMIT_W-1:0]  limit,
  output gaps_pkg::eng_stat_t                stat,
  output gaps_pkg::path_wr_t                 path_wr
);
  import gaps_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_CLEAR  = 15'h0002,
    S_INIT   = 15'h0004,
    S_LOOP   = 15'h0008,
    S_SCAN   = 15'h0010,
    S_PICK   = 15'h0020,
    S_MOVE   = 15'h0040,
    S_NB_RD  = 15'h0080,
    S_NB_UPD = 15'h0100,
    S_TC_RD  = 15'h0200,
    S_TC_WT  = 15'h0400,
    S_TW     = 15'h0800,
    S_TW_WT  = 15'h1000,
    S_DONE   = 15'h2000,
    S_MCLR   = 15'h4000
  } state_t;

  // memories
  logic [3:0]        map_mem  [CELL_COUNT];
  node_t             node_mem [CELL_COUNT];
  logic [CELL_W-1:0] open_mem [CELL_COUNT];

  logic [3:0]        map_rdata_r;
  node_t             node_rdata_r;
  logic [CELL_W-1:0] open_rdata_r;

  logic              map_we_i;
  logic [CELL_W-1:0] map_waddr;
  logic [3:0]        map_wdata;
  logic              node_we;
  logic [CELL_W-1:0] node_waddr, node_raddr;
  node_t             node_wdata;
  logic              open_we;
  logic [CELL_W-1:0] open_waddr, open_raddr, open_wdata;

  state_t            state_r, state_nxt;
  logic [CELL_W-1:0] clr_r, clr_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LIMIT_W-1:0] iter_r, iter_nxt;
  logic [LEN_W-1:0]  rd_i_r, rd_i_nxt;
  logic              p1_v_r, p1_v_nxt, p2_v_r, p2_v_nxt;
  logic [CELL_W-1:0] p1_idx_r, p1_idx_nxt, p2_idx_r, p2_idx_nxt, p2_cell_r, p2_cell_nxt;
  logic [F_W-1:0]    bf_r, bf_nxt;
  logic [EST_W-1:0]  bh_r, bh_nxt;
  logic [CELL_W-1:0] best_idx_r, best_idx_nxt, best_cell_r, best_cell_nxt;
  node_t             best_node_r, best_node_nxt;
  logic [3:0]        sides_r, sides_nxt;
  logic [1:0]        nb_r, nb_nxt;
  logic [CELL_W-1:0] nb_cell_r, nb_cell_nxt;
  logic [CELL_W-1:0] start_r, start_nxt, goal_r, goal_nxt;
  logic [CELL_W-1:0] trc_r, trc_nxt;
  logic              trc_none_r, trc_none_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, k_r, k_nxt;
  logic              found_r, found_nxt;
  logic [LEN_W-1:0]  stored_r, stored_nxt;

  logic [F_W-1:0]    scan_f;
  logic [COORD_W-1:0] cx, cy;
  logic              nb_ok;
  logic [CELL_W-1:0] nb_n;
  logic [COST_W-1:0] g_new;

  always_ff @(posedge clk) begin
    if (map_we_i) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_r <= map_mem[best_cell_r];
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata_r <= node_mem[node_raddr];
    if (open_we) begin
      open_mem[open_waddr] <= open_wdata;
    end
    open_rdata_r <= open_mem[open_raddr];
  end

  assign scan_f = F_W'(node_rdata_r.cost) + F_W'(node_rdata_r.est);
  assign cx     = best_cell_r[7:4];
  assign cy     = best_cell_r[3:0];
  assign g_new  = best_node_r.cost + COST_W'(1);

  // neighbor order: up, right, down, left
  always_comb begin
    nb_ok = 1'b0;
    nb_n  = best_cell_r;
    case (nb_r)
      2'd0: begin
        nb_ok = |(sides_r & SIDE_UP) && (cy != '1);
        nb_n  = {cx, cy + COORD_W'(1)};
      end
      2'd1: begin
        nb_ok = |(sides_r & SIDE_RIGHT) && (cx != '1);
        nb_n  = {cx + COORD_W'(1), cy};
      end
      2'd2: begin
        nb_ok = |(sides_r & SIDE_DOWN) && (cy != '0);
        nb_n  = {cx, cy - COORD_W'(1)};
      end
      default: begin
        nb_ok = |(sides_r & SIDE_LEFT) && (cx != '0);
        nb_n  = {cx - COORD_W'(1), cy};
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    iter_nxt      = iter_r;
    rd_i_nxt      = rd_i_r;
    p1_v_nxt      = 1'b0;
    p1_idx_nxt    = p1_idx_r;
    p2_v_nxt      = 1'b0;
    p2_idx_nxt    = p2_idx_r;
    p2_cell_nxt   = p2_cell_r;
    bf_nxt        = bf_r;
    bh_nxt        = bh_r;
    best_idx_nxt  = best_idx_r;
    best_cell_nxt = best_cell_r;
    best_node_nxt = best_node_r;
    sides_nxt     = sides_r;
    nb_nxt        = nb_r;
    nb_cell_nxt   = nb_cell_r;
    start_nxt     = start_r;
    goal_nxt      = goal_r;
    trc_nxt       = trc_r;
    trc_none_nxt  = trc_none_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    stored_nxt    = stored_r;

    map_we_i   = map_we;
    map_waddr  = map_cell;
    map_wdata  = map_sides;
    node_we    = 1'b0;
    node_waddr = clr_r;
    node_wdata = '{cost: COST_INF, est: '0, no_parent: 1'b1, parent: '0, closed: 1'b0};
    node_raddr = open_rdata_r;
    open_we    = 1'b0;
    open_waddr = count_r[CELL_W-1:0];
    open_wdata = nb_cell_r;
    open_raddr = rd_i_r[CELL_W-1:0];
    path_wr    = '{we: 1'b0, addr: '0, loc: trc_r};

    case (state_r)
      S_MCLR: begin
        // after reset every map entry is written to all sides blocked
        map_we_i  = 1'b1;
        map_waddr = clr_r;
        map_wdata = '0;
        clr_nxt   = clr_r + CELL_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (search_go) begin
          start_nxt  = start_cell;
          goal_nxt   = goal_cell;
          found_nxt  = 1'b0;
          stored_nxt = '0;
          count_nxt  = '0;
          clr_nxt    = '0;
          state_nxt  = S_CLEAR;
        end
      end
      S_CLEAR: begin
        node_we = 1'b1;
        clr_nxt = clr_r + CELL_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        node_we    = 1'b1;
        node_waddr = start_r;
        node_wdata = '{cost: '0, est: manhattan(start_r, goal_r), no_parent: 1'b1,
                       parent: '0, closed: 1'b0};
        open_we    = 1'b1;
        open_waddr = '0;
        open_wdata = start_r;
        count_nxt  = LEN_W'(1);
        iter_nxt   = '0;
        state_nxt  = S_LOOP;
      end
      S_LOOP: begin
        if (count_r == '0 || iter_r >= limit) begin
          state_nxt = S_DONE;
        end else begin
          iter_nxt  = iter_r + LIMIT_W'(1);
          rd_i_nxt  = '0;
          bf_nxt    = '1;
          bh_nxt    = '1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // slot read -> node read -> compare, one slot entering per cycle
        if (rd_i_r < count_r) begin
          p1_v_nxt   = 1'b1;
          p1_idx_nxt = rd_i_r[CELL_W-1:0];
          rd_i_nxt   = rd_i_r + LEN_W'(1);
        end
        p2_v_nxt    = p1_v_r;
        p2_idx_nxt  = p1_idx_r;
        p2_cell_nxt = open_rdata_r;
        if (p2_v_r && (scan_f < bf_r || (scan_f == bf_r && node_rdata_r.est < bh_r))) begin
          bf_nxt        = scan_f;
          bh_nxt        = node_rdata_r.est;
          best_idx_nxt  = p2_idx_r;
          best_cell_nxt = p2_cell_r;
          best_node_nxt = node_rdata_r;
        end
        if (rd_i_r >= count_r && !p1_v_r && !p2_v_r) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (best_cell_r == goal_r) begin
          trc_nxt      = best_cell_r;
          trc_none_nxt = 1'b0;
          len_nxt      = '0;
          state_nxt    = S_TC_RD;
        end else begin
          open_raddr = 8'(count_r - LEN_W'(1));
          state_nxt  = S_MOVE;
        end
      end
      S_MOVE: begin
        open_we    = 1'b1;
        open_waddr = best_idx_r;
        open_wdata = open_rdata_r;
        count_nxt  = count_r - LEN_W'(1);
        node_we    = 1'b1;
        node_waddr = best_cell_r;
        node_wdata = best_node_r;
        node_wdata.closed = 1'b1;
        sides_nxt  = map_rdata_r;
        nb_nxt     = '0;
        state_nxt  = S_NB_RD;
      end
      S_NB_RD: begin
        node_raddr  = nb_n;
        nb_cell_nxt = nb_n;
        if (nb_ok) begin
          state_nxt = S_NB_UPD;
        end else if (nb_r == 2'd3) begin
          state_nxt = S_LOOP;
        end else begin
          nb_nxt = nb_r + 2'd1;
        end
      end
      S_NB_UPD: begin
        if (!node_rdata_r.closed && g_new < node_rdata_r.cost) begin
          node_we    = 1'b1;
          node_waddr = nb_cell_r;
          node_wdata = '{cost: g_new, est: manhattan(nb_cell_r, goal_r), no_parent: 1'b0,
                         parent: best_cell_r, closed: 1'b0};
          // a never-reached cell is not yet on the open list
          if (node_rdata_r.cost == COST_INF && count_r < LEN_W'(CELL_COUNT)) begin
            open_we   = 1'b1;
            count_nxt = count_r + LEN_W'(1);
          end
        end
        if (nb_r == 2'd3) begin
          state_nxt = S_LOOP;
        end else begin
          nb_nxt    = nb_r + 2'd1;
          state_nxt = S_NB_RD;
        end
      end
      S_TC_RD: begin
        node_raddr = trc_r;
        if (trc_none_r || len_r == PATH_FULL_LEN) begin
          trc_nxt      = best_cell_r;
          trc_none_nxt = 1'b0;
          k_nxt        = '0;
          state_nxt    = S_TW;
        end else begin
          state_nxt = S_TC_WT;
        end
      end
      S_TC_WT: begin
        len_nxt      = len_r + LEN_W'(1);
        trc_nxt      = node_rdata_r.parent;
        trc_none_nxt = node_rdata_r.no_parent;
        state_nxt    = S_TC_RD;
      end
      S_TW: begin
        node_raddr = trc_r;
        if (k_r == len_r) begin
          found_nxt  = 1'b1;
          stored_nxt = len_r;
          state_nxt  = S_DONE;
        end else begin
          // walking back from the goal fills the store from its end
          path_wr.we   = 1'b1;
          path_wr.addr = 8'(len_r - LEN_W'(1) - k_r);
          state_nxt    = S_TW_WT;
        end
      end
      S_TW_WT: begin
        trc_nxt   = node_rdata_r.parent;
        k_nxt     = k_r + LEN_W'(1);
        state_nxt = S_TW;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_MCLR;
      clr_r    <= '0;
      count_r  <= '0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      found_r  <= 1'b0;
      stored_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      p1_v_r   <= p1_v_nxt;
      p2_v_r   <= p2_v_nxt;
      found_r  <= found_nxt;
      stored_r <= stored_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r      <= iter_nxt;
    rd_i_r      <= rd_i_nxt;
    p1_idx_r    <= p1_idx_nxt;
    p2_idx_r    <= p2_idx_nxt;
    p2_cell_r   <= p2_cell_nxt;
    bf_r        <= bf_nxt;
    bh_r        <= bh_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cell_r <= best_cell_nxt;
    best_node_r <= best_node_nxt;
    sides_r     <= sides_nxt;
    nb_r        <= nb_nxt;
    nb_cell_r   <= nb_cell_nxt;
    start_r     <= start_nxt;
    goal_r      <= goal_nxt;
    trc_r       <= trc_nxt;
    trc_none_r  <= trc_none_nxt;
    len_r       <= len_nxt;
    k_r         <= k_nxt;
  end

  assign stat = '{busy: (state_r != S_IDLE), done: (state_r == S_DONE),
                  found: found_r, length: stored_r};

endmodule
`default_nettype wire

// File: sv/grid_astar_path_search.sv
// Top level of the grid A* path search: item channel, config port, result strobe.
//
// Items enter on start/busy: an item is taken at a clock edge with start high
// and busy low. in_action selects a map cell write, a search from
// (in_cell_x, in_cell_y) to (in_goal_x, in_goal_y), or a read of path entry
// in_path_index. Every item gives one result, shown for one cycle with
// out_valid high; the receiver cannot stall it.
// Map writes and path reads take one cycle: the result follows the accepting
// edge by one cycle and a new item may be taken every cycle.
// A search holds busy high while the sequencer works through the node memory:
// it clears the node records, then per expansion scans the open list to pick
// and remove the best open entry and checks the four neighbors, then traces
// back from the goal to count and store the path. The result comes out in
// the cycle busy drops.
// iteration_limit (APB, address 0, reset 1000) bounds expansions per search.
// Reset sets the status to not found with an empty path and the limit to its
// reset value; busy then stays high while the map is cleared to all sides
// blocked.
`default_nettype none
module grid_astar_path_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [3:0]  in_cell_x,
  input  wire logic [3:0]  in_cell_y,
  input  wire logic [3:0]  in_open_sides,
  input  wire logic [3:0]  in_goal_x,
  input  wire logic [3:0]  in_goal_y,
  input  wire logic [7:0]  in_path_index,
  output logic             out_valid,
  output logic             out_found,
  output logic [8:0]       out_path_length,
  output logic             out_step_valid,
  output logic [3:0]       out_step_x,
  output logic [3:0]       out_step_y,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gaps_pkg::*;

  logic               accept;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r, out_valid_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0]  path_rdata_r;
  eng_stat_t          stat;
  path_wr_t           path_wr;

  assign accept = start && !busy;
  assign busy   = stat.busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  gaps_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_we     (accept && in_action == ACT_MAP_WRITE),
    .map_cell   ({in_cell_x, in_cell_y}),
    .map_sides  (in_open_sides),
    .search_go  (accept && in_action == ACT_SEARCH),
    .start_cell ({in_cell_x, in_cell_y}),
    .goal_cell  ({in_goal_x, in_goal_y}),
    .limit      (limit_r),
    .stat       (stat),
    .path_wr    (path_wr)
  );

  gaps_path_store u_path (
    .clk     (clk),
    .wr      (path_wr),
    .raddr   (in_path_index),
    .rdata_r (path_rdata_r)
  );

  always_comb begin
    out_valid_nxt = (accept && in_action != ACT_SEARCH) || stat.done;
    rd_ok_nxt     = accept && in_action == ACT_PATH_READ &&
                    LEN_W'(in_path_index) < stat.length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = stat.found;
  assign out_path_length = stat.length;
  assign out_step_valid  = rd_ok_r;
  assign out_step_x      = rd_ok_r ? path_rdata_r[7:4] : '0;
  assign out_step_y      = rd_ok_r ? path_rdata_r[3:0] : '0;

  // a finished search always reports in the cycle busy drops
  a_search_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(stat.done)) |-> out_valid)
    else $error("search ended without a result");

  a_step_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_step_valid |-> out_valid && out_path_length != '0)
    else $error("path step outside a read result");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_found |-> out_path_length == '0)
    else $error("path length kept after a failed search");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_SEARCH) |=> busy)
    else $error("search item did not raise busy");

endmodule
`default_nettype wire
